/* rtl/core/pip_pkg.sv */
package pip_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int VTX_AW       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 9;
  localparam int IDX_W        = 8;
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  // far end of the test segment: lat 0, lon 170 degrees in 2^-22 degree units
  localparam logic signed [COORD_W-1:0] FAR_LAT = 32'sd0;
  localparam logic signed [COORD_W-1:0] FAR_LON = 32'sd713031680;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OR_COLL = 2'd0,
    OR_CW   = 2'd1,
    OR_CCW  = 2'd2
  } orient_t;

  typedef struct packed {
    logic                      mode;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] point_lat;
    logic signed [COORD_W-1:0] point_lon;
  } in_item_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] crossing_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
  } vertex_t;

  typedef struct packed {
    logic              we;
    logic [VTX_AW-1:0] waddr;
    vertex_t           wdata;
    logic              re;
    logic [VTX_AW-1:0] raddr;
  } ram_ctl_t;

  typedef struct packed {
    logic    vld;
    logic    last;
    vertex_t a;
    vertex_t b;
    vertex_t p;
  } seg_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic hit;
  } seg_res_t;

endpackage

/* rtl/core/pip_ram.sv */
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pip_orient.sv */
module pip_orient (
  input  logic              clk,
  input  logic              rst,
  input  pip_pkg::seg_t     seg_i,
  output pip_pkg::seg_res_t res
);
  import pip_pkg::*;

  function automatic logic signed [DIFF_W-1:0] dsub(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
    return $signed({x[COORD_W-1], x}) - $signed({y[COORD_W-1], y});
  endfunction

  // q between p and r on one axis
  function automatic logic rng(input logic [COORD_W-1:0] q, input logic [COORD_W-1:0] p,
                               input logic [COORD_W-1:0] r);
    return (($signed(q) <= $signed(p)) || ($signed(q) <= $signed(r))) &&
           (($signed(q) >= $signed(p)) || ($signed(q) >= $signed(r)));
  endfunction

  function automatic logic in_box(input vertex_t q, input vertex_t p, input vertex_t r);
    return rng(q.lat, p.lat, r.lat) && rng(q.lon, p.lon, r.lon);
  endfunction

  function automatic orient_t orient_of(input logic signed [PROD_W-1:0] m1,
                                        input logic signed [PROD_W-1:0] m2);
    logic signed [PROD_W:0] d;
    d = $signed({m1[PROD_W-1], m1}) - $signed({m2[PROD_W-1], m2});
    if (d == '0) begin
      return OR_COLL;
    end else if (d[PROD_W]) begin
      return OR_CCW;
    end
    return OR_CW;
  endfunction

  vertex_t far_vtx;
  assign far_vtx = '{lat: FAR_LAT, lon: FAR_LON};

  // stage 1: coordinate differences and bounding box flags
  logic                     s1_vld, s1_last;
  logic signed [DIFF_W-1:0] ab_y, ab_x, bp_x, bp_y, bf_x, bf_y;
  logic signed [DIFF_W-1:0] pf_y, pf_x, fa_x, fa_y, fb_x, fb_y;
  logic [3:0]               s1_box;

  // stage 2: products
  logic                     s2_vld, s2_last;
  logic signed [PROD_W-1:0] s2_m [8];
  logic [3:0]               s2_box;

  // stage 3: orientation codes
  logic                     s3_vld, s3_last;
  orient_t                  s3_o [4];
  logic [3:0]               s3_box;

  logic hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      res.vld <= 1'b0;
    end else begin
      s1_vld  <= seg_i.vld;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      res.vld <= s3_vld;
    end

    s1_last <= seg_i.last;
    ab_y    <= dsub(seg_i.b.lon, seg_i.a.lon);
    ab_x    <= dsub(seg_i.b.lat, seg_i.a.lat);
    bp_x    <= dsub(seg_i.p.lat, seg_i.b.lat);
    bp_y    <= dsub(seg_i.p.lon, seg_i.b.lon);
    bf_x    <= dsub(far_vtx.lat, seg_i.b.lat);
    bf_y    <= dsub(far_vtx.lon, seg_i.b.lon);
    pf_y    <= dsub(far_vtx.lon, seg_i.p.lon);
    pf_x    <= dsub(far_vtx.lat, seg_i.p.lat);
    fa_x    <= dsub(seg_i.a.lat, far_vtx.lat);
    fa_y    <= dsub(seg_i.a.lon, far_vtx.lon);
    fb_x    <= dsub(seg_i.b.lat, far_vtx.lat);
    fb_y    <= dsub(seg_i.b.lon, far_vtx.lon);
    s1_box  <= {in_box(seg_i.b, seg_i.p, far_vtx), in_box(seg_i.a, seg_i.p, far_vtx),
                in_box(far_vtx, seg_i.a, seg_i.b), in_box(seg_i.p, seg_i.a, seg_i.b)};

    s2_last  <= s1_last;
    s2_m[0]  <= ab_y * bp_x;
    s2_m[1]  <= ab_x * bp_y;
    s2_m[2]  <= ab_y * bf_x;
    s2_m[3]  <= ab_x * bf_y;
    s2_m[4]  <= pf_y * fa_x;
    s2_m[5]  <= pf_x * fa_y;
    s2_m[6]  <= pf_y * fb_x;
    s2_m[7]  <= pf_x * fb_y;
    s2_box   <= s1_box;

    s3_last  <= s2_last;
    s3_o[0]  <= orient_of(s2_m[0], s2_m[1]);
    s3_o[1]  <= orient_of(s2_m[2], s2_m[3]);
    s3_o[2]  <= orient_of(s2_m[4], s2_m[5]);
    s3_o[3]  <= orient_of(s2_m[6], s2_m[7]);
    s3_box   <= s2_box;

    res.last <= s3_last;
    res.hit  <= hit;
  end

  // proper crossing, or a collinear touch inside the other segment's box
  always_comb begin
    hit = ((s3_o[0] != s3_o[1]) && (s3_o[2] != s3_o[3])) ||
          ((s3_o[0] == OR_COLL) && s3_box[0]) ||
          ((s3_o[1] == OR_COLL) && s3_box[1]) ||
          ((s3_o[2] == OR_COLL) && s3_box[2]) ||
          ((s3_o[3] == OR_COLL) && s3_box[3]);
  end

endmodule

/* rtl/core/pip_seq.sv */
module pip_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  pip_pkg::in_item_t         req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output pip_pkg::out_item_t        rsp,
  input  logic                      cfg_wen,
  input  logic [pip_pkg::CNT_W-1:0] cfg_wdata,
  output pip_pkg::ram_ctl_t         ram_ctl,
  input  pip_pkg::vertex_t          rd_vtx,
  output pip_pkg::seg_t             seg_o,
  input  pip_pkg::seg_res_t         res
);
  import pip_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] n_edges;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] hits;
  logic             rd_vld;
  logic             close_pend;
  vertex_t          qpt;
  vertex_t          first_vtx;
  vertex_t          prev_vtx;

  logic             req_acc;
  logic             rd_issue;
  logic [CNT_W-1:0] n_clamp;

  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rd_issue  = (state == ST_RUN) && (rd_cnt < n_edges);

  always_comb begin
    if (32'(vertex_count) > MAX_VERTICES) begin
      n_clamp = CNT_W'(MAX_VERTICES);
    end else begin
      n_clamp = vertex_count;
    end
  end

  always_comb begin
    ram_ctl.we    = req_acc && (req.mode == MODE_WRITE) &&
                    (32'(req.vertex_index) < MAX_VERTICES);
    ram_ctl.waddr = VTX_AW'(req.vertex_index);
    ram_ctl.wdata = '{lat: req.point_lat, lon: req.point_lon};
    ram_ctl.re    = rd_issue;
    ram_ctl.raddr = VTX_AW'(rd_cnt);
  end

  // edge i-1 -> i as each vertex arrives, then the closing edge last -> first
  always_comb begin
    seg_o.vld  = (rd_vld && (rd_idx != '0)) || close_pend;
    seg_o.last = close_pend;
    seg_o.a    = prev_vtx;
    seg_o.b    = close_pend ? first_vtx : rd_vtx;
    seg_o.p    = qpt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= '0;
      rd_vld       <= 1'b0;
      close_pend   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        vertex_count <= cfg_wdata;
      end
      // the finish state reloads the output register itself
      if (rsp_valid && !rsp_stall && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end

      rd_vld     <= rd_issue;
      close_pend <= rd_vld && (rd_idx == n_edges - 1'b1);
      if (rd_issue) begin
        rd_idx <= rd_cnt;
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (rd_vld) begin
        prev_vtx <= rd_vtx;
        if (rd_idx == '0) begin
          first_vtx <= rd_vtx;
        end
      end
      if (res.vld && res.hit) begin
        hits <= hits + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (req_acc && (req.mode == MODE_QUERY)) begin
            qpt     <= '{lat: req.point_lat, lon: req.point_lon};
            n_edges <= n_clamp;
            rd_cnt  <= '0;
            hits    <= '0;
            state   <= (n_clamp == '0) ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          if (res.vld && res.last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid          <= 1'b1;
            rsp.inside_res     <= hits[0];
            rsp.crossing_count <= hits;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/point_in_polygon_crossing_test.sv */
// channel  | direction | transfer when          | payload
// req      | in        | req_valid && !req_stall | in_item_t: mode, index, lat, lon
// rsp      | out       | rsp_valid && !rsp_stall | out_item_t: inside flag, count
// cfg      | in        | cfg_wen                 | vertex_count
//
// a query with n vertices reads one vertex per cycle from the vertex rams and runs
// each edge through the four stage edge test
// reset clears vertex_count, the state and the valid flags; vertex ram contents stay undefined
// req is stalled while a query runs or its result waits for the output register
// rsp holds its result until the transfer, and one more query may run meanwhile
module point_in_polygon_crossing_test (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  pip_pkg::in_item_t         req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output pip_pkg::out_item_t        rsp,
  input  logic                      cfg_wen,
  input  logic [pip_pkg::CNT_W-1:0] cfg_wdata
);
  import pip_pkg::*;

  ram_ctl_t ram_ctl;
  vertex_t  rd_vtx;
  seg_t     seg;
  seg_res_t seg_res;

  // sequencer: vertex writes, edge walk, crossing count and output register
  pip_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .ram_ctl   (ram_ctl),
    .rd_vtx    (rd_vtx),
    .seg_o     (seg),
    .res       (seg_res)
  );

  // latitude store
  pip_ram #(
    .WIDTH (COORD_W),
    .DEPTH (MAX_VERTICES)
  ) u_lat_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wdata.lat),
    .re    (ram_ctl.re),
    .raddr (ram_ctl.raddr),
    .rdata (rd_vtx.lat)
  );

  // longitude store
  pip_ram #(
    .WIDTH (COORD_W),
    .DEPTH (MAX_VERTICES)
  ) u_lon_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wdata.lon),
    .re    (ram_ctl.re),
    .raddr (ram_ctl.raddr),
    .rdata (rd_vtx.lon)
  );

  // per edge orientation test against the segment to the far point
  pip_orient u_orient (
    .clk   (clk),
    .rst   (rst),
    .seg_i (seg),
    .res   (seg_res)
  );

endmodule

/* tb/point_in_polygon_crossing_test_tb.sv */
`timescale 1ns / 1ps

module point_in_polygon_crossing_test_tb;
  import pip_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int PRESSURE_ROUND = 4;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int CMIN = 32'sh8000_0000;
  localparam int CMAX = 32'sh7fff_ffff;
  localparam int SQ   = 1 << 20;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  in_item_t           req       = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  out_item_t          rsp;
  logic               cfg_wen   = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata = '0;

  point_in_polygon_crossing_test dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // stimulus side: pending transfers and what the generator knows of the store
  in_item_t  stim_q[$];
  vertex_t   gen_vtx [MAX_VERTICES];
  bit        all_written   = 1'b0;
  int        items_made    = 0;
  int        coord_style   = 0;
  int        grid_shift    = 4;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_arm      = 0;

  // predictor side: own copy of the vertex store and the vertex count
  vertex_t   shadow_vtx [MAX_VERTICES];
  logic [CNT_W-1:0] poly_size = '0;
  out_item_t crossing_answers[$];
  int        mismatches = 0;
  longint    cycle_no   = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // sign of the cross product, evaluated exactly at 68 bits
  function automatic orient_t turn_of(vertex_t p, vertex_t q, vertex_t r);
    logic signed [67:0] dy1, dx1, dx0, dy0, s;
    dy1 = $signed(q.lon) - $signed(p.lon);
    dx1 = $signed(r.lat) - $signed(q.lat);
    dx0 = $signed(q.lat) - $signed(p.lat);
    dy0 = $signed(r.lon) - $signed(q.lon);
    s   = dy1 * dx1 - dx0 * dy0;
    if (s == 0) return OR_COLL;
    return (s > 0) ? OR_CW : OR_CCW;
  endfunction

  // q within the bounding box of p and r
  function automatic bit in_box(vertex_t p, vertex_t q, vertex_t r);
    logic signed [COORD_W-1:0] px, py, qx, qy, rx, ry;
    px = $signed(p.lat); py = $signed(p.lon);
    qx = $signed(q.lat); qy = $signed(q.lon);
    rx = $signed(r.lat); ry = $signed(r.lon);
    return (qx <= px || qx <= rx) && (qx >= px || qx >= rx) &&
           (qy <= py || qy <= ry) && (qy >= py || qy >= ry);
  endfunction

  // edge a-b against test segment p-f, collinear touches count as a hit
  function automatic bit edge_meets(vertex_t a, vertex_t b, vertex_t p, vertex_t f);
    orient_t o1, o2, o3, o4;
    o1 = turn_of(a, b, p);
    o2 = turn_of(a, b, f);
    o3 = turn_of(p, f, a);
    o4 = turn_of(p, f, b);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == OR_COLL && in_box(a, p, b)) return 1'b1;
    if (o2 == OR_COLL && in_box(a, f, b)) return 1'b1;
    if (o3 == OR_COLL && in_box(p, a, f)) return 1'b1;
    if (o4 == OR_COLL && in_box(p, b, f)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic out_item_t count_crossings(vertex_t pt);
    vertex_t   far_pt;
    out_item_t res;
    int        n;
    int        j;
    int        cnt;
    far_pt.lat = FAR_LAT;
    far_pt.lon = FAR_LON;
    // counts beyond the store size are clamped to the store size
    n   = (poly_size > MAX_VERTICES) ? MAX_VERTICES : int'(poly_size);
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 < n) ? i + 1 : 0;
      if (edge_meets(shadow_vtx[i], shadow_vtx[j], pt, far_pt)) cnt++;
    end
    res.inside_res     = cnt[0];
    res.crossing_count = cnt[CNT_W-1:0];
    return res;
  endfunction

  // apply one accepted request transfer to the predictor
  function automatic void track_transfer(in_item_t it);
    vertex_t v;
    v.lat = it.point_lat;
    v.lon = it.point_lon;
    if (it.mode == MODE_WRITE) begin
      shadow_vtx[it.vertex_index] = v;
    end else begin
      crossing_answers.push_back(count_crossings(v));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: feeds request transfers from stim_q, holds payload while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) track_transfer(req);
      if (!req_valid || !req_stall) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= stim_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each response transfer, drives rsp_stall
  // ---------------------------------------------------------------------------
  int hold_left  = 0;
  int hold_taken = 0;

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (crossing_answers.size() == 0) begin
          $error("result with no query pending: inside_res %0d crossing_count %0d",
                 rsp.inside_res, rsp.crossing_count);
          mismatches++;
        end else begin
          want = crossing_answers.pop_front();
          if (rsp.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0d, got %0d", want.inside_res, rsp.inside_res);
            mismatches++;
          end
          if (rsp.crossing_count !== want.crossing_count) begin
            $error("crossing_count: expected %0d, got %0d",
                   want.crossing_count, rsp.crossing_count);
            mismatches++;
          end
        end
      end
      // long hold-off so the block backs up into its request side
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_stall <= 1'b1;
      end else if (hold_taken != hold_arm) begin
        hold_taken <= hold_arm;
        hold_left  <= HOLD_CYCLES;
        rsp_stall  <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic vertex_t vtx(int lat, int lon);
    vertex_t v;
    v.lat = lat;
    v.lon = lon;
    return v;
  endfunction

  // full range, a coarse grid around the far point (many collinear cases),
  // or a moderate spread of ordinary coordinates
  function automatic vertex_t pick_point();
    vertex_t v;
    case (coord_style)
      0: begin
        v.lat = $urandom;
        v.lon = $urandom;
      end
      1: begin
        v.lat = (int'($urandom_range(6)) - 3) <<< grid_shift;
        v.lon = FAR_LON + ((int'($urandom_range(8)) - 6) <<< grid_shift);
      end
      default: begin
        v.lat = $signed($urandom) >>> 6;
        v.lon = $signed($urandom) >>> 1;
      end
    endcase
    return v;
  endfunction

  task automatic push_item(logic mode, logic [IDX_W-1:0] idx, vertex_t v);
    in_item_t it;
    it.mode         = mode;
    it.vertex_index = idx;
    it.point_lat    = v.lat;
    it.point_lon    = v.lon;
    stim_q.push_back(it);
    items_made++;
  endtask

  task automatic put_vertex(int idx, vertex_t v);
    gen_vtx[idx] = v;
    push_item(MODE_WRITE, IDX_W'(idx), v);
  endtask

  task automatic put_query(vertex_t v);
    push_item(MODE_QUERY, IDX_W'($urandom), v);
  endtask

  // query point: random, sitting on a vertex, or halfway along an edge
  task automatic put_random_query(int m);
    int      pick;
    int      i;
    vertex_t a, b, v;
    pick = $urandom_range(9);
    if (m != 0 && pick < 2) begin
      v = gen_vtx[$urandom_range(m - 1)];
    end else if (m != 0 && pick < 4) begin
      i = $urandom_range(m - 1);
      a = gen_vtx[i];
      b = gen_vtx[(i + 1) % m];
      v.lat = ($signed(a.lat) >>> 1) + ($signed(b.lat) >>> 1);
      v.lon = ($signed(a.lon) >>> 1) + ($signed(b.lon) >>> 1);
    end else begin
      v = pick_point();
    end
    put_query(v);
  endtask

  // thirds of the run: sender idles less, then more, then neither idles
  task automatic pick_idling();
    if (items_made < ITEM_TARGET / 3) begin
      send_idle_pct = 24;
      recv_idle_pct = 49;
    end else if (items_made < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 49;
      recv_idle_pct = 24;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // wait until every transfer went in and every result came out, then let
  // a trailing vertex write finish
  task automatic quiesce();
    do @(negedge clk);
    while (stim_q.size() != 0 || req_valid || crossing_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_vertex_count(int n);
    quiesce();
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= CNT_W'(n);
    poly_size <= CNT_W'(n);
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n, m, nq, j, tmp, wcount, round_no;
    int order [MAX_VERTICES];

    pick_idling();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // square around the origin
    write_vertex_count(4);
    put_vertex(0, vtx(-SQ, -SQ));
    put_vertex(1, vtx(-SQ, SQ));
    put_vertex(2, vtx(SQ, SQ));
    put_vertex(3, vtx(SQ, -SQ));
    // inside, and outside past the far edge
    put_query(vtx(0, 0));
    put_query(vtx(0, 2 * SQ));
    // point lying on an edge
    put_query(vtx(0, SQ));
    put_query(vtx(-SQ, 0));
    // ray running exactly through a corner
    put_query(vtx(2 * SQ, 2 * SQ - FAR_LON));
    // extreme coordinates, index field at both ends
    push_item(MODE_QUERY, 8'hff, vtx(CMIN, CMIN));
    push_item(MODE_QUERY, 8'h00, vtx(CMAX, CMAX));
    put_vertex(MAX_VERTICES - 1, vtx(CMAX, CMIN));

    // triangle spanning the whole coordinate range
    write_vertex_count(3);
    put_vertex(0, vtx(CMIN, CMIN));
    put_vertex(1, vtx(CMAX, CMIN));
    put_vertex(2, vtx(0, CMAX));
    put_query(vtx(0, 0));
    put_query(vtx(CMIN, CMAX));

    // single vertex: zero-length edge, hit only when it lies on the test segment
    write_vertex_count(1);
    put_query(vtx(CMIN, CMIN));
    put_query(vtx(0, 0));

    // two vertices: the same edge twice
    write_vertex_count(2);
    put_query(vtx(0, 0));
    put_query(vtx(0, CMIN));

    // empty polygon
    write_vertex_count(0);
    put_query(vtx(0, 0));

    // random outlines, each followed by queries
    round_no = 0;
    while (items_made < ITEM_TARGET) begin
      pick_idling();
      coord_style = $urandom_range(2);
      grid_shift  = $urandom_range(22, 4);
      if (round_no == 0) begin
        n = MAX_VERTICES;
      end else if (round_no == 1) begin
        n = (1 << CNT_W) - 1;
      end else begin
        tmp = $urandom_range(99);
        if (tmp < 3)       n = 0;
        else if (tmp < 8)  n = 1;
        else if (tmp < 13) n = 2;
        else if (tmp < 15) n = MAX_VERTICES;
        else if (tmp < 17) n = $urandom_range((1 << CNT_W) - 1, MAX_VERTICES + 1);
        else               n = $urandom_range(20, 3);
      end
      write_vertex_count(n);
      m = (n > MAX_VERTICES) ? MAX_VERTICES : n;

      // write the outline in shuffled slot order; a full store that is
      // already loaded only gets part of it rewritten
      for (int k = 0; k < m; k++) order[k] = k;
      for (int k = m - 1; k > 0; k--) begin
        j        = $urandom_range(k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      wcount = (m == MAX_VERTICES && all_written) ? 32 : m;
      for (int k = 0; k < wcount; k++) begin
        put_vertex(order[k], pick_point());
        // stray writes to unused slots
        if (m < MAX_VERTICES && $urandom_range(9) == 0)
          put_vertex($urandom_range(MAX_VERTICES - 1, m), pick_point());
        // query in the middle of a rewrite, legal once every slot holds data
        if (all_written && $urandom_range(9) == 0) put_random_query(m);
      end
      if (m == MAX_VERTICES) all_written = 1'b1;

      if (round_no == PRESSURE_ROUND) hold_arm++;
      nq = (m >= 64) ? $urandom_range(4, 2) : $urandom_range(12, 3);
      repeat (nq) put_random_query(m);
      round_no++;
    end

    quiesce();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/pip_pkg.sv
rtl/core/pip_ram.sv
rtl/core/pip_orient.sv
rtl/core/pip_seq.sv
rtl/core/point_in_polygon_crossing_test.sv
tb/point_in_polygon_crossing_test_tb.sv
